// ----- rtl/core/vector_distance_accumulator_assert.svh -----
// Assertion macros for the vector distance accumulator.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef VECTOR_DISTANCE_ACCUMULATOR_ASSERT_SVH
`define VECTOR_DISTANCE_ACCUMULATOR_ASSERT_SVH

// Checked outside reset.
`define VDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define VDA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/vda_pkg.sv -----
// Package for the vector distance accumulator: payload structs, distance
// modes, controller states and the command and status groups. No dependencies.
package vda_pkg;

  localparam int ELEM_W = 16;
  localparam int ACC_W = 45;
  localparam int COUNT_W = 13;
  localparam int ROOT_W = (ACC_W + 1) / 2;
  localparam int ROOT_REM_W = ROOT_W + 2;
  localparam int DIV_STEPS = ACC_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W = 6;

  typedef enum logic [1:0] {
    MODE_SAD    = 2'd0,
    MODE_SSD    = 2'd1,
    MODE_MAE    = 2'd2,
    MODE_EUCLID = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_DIVIDE,
    ST_ROOT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]   distance;
    logic [COUNT_W-1:0] element_count;
    logic               length_overflow;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic clear_work;
    logic div_step;
    logic root_step;
    logic root_first;
    logic emit;
    logic emit_root;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  out_blocked;
  } status_t;

endpackage

// ----- rtl/core/vda_controller.sv -----
// Controller for the vector distance accumulator: sequences accumulation,
// the final divide or square root, and the result hand-off. Uses vda_pkg.
module vda_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  input  vda_pkg::status_t status,
  output vda_pkg::cmd_t    cmd
);

  vda_pkg::state_t state, state_next;
  logic [vda_pkg::STEP_W-1:0] step, step_next;
  vda_pkg::mode_t final_mode, final_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vda_pkg::ST_ACCUM;
      step       <= '0;
      final_mode <= vda_pkg::MODE_SAD;
    end else begin
      state      <= state_next;
      step       <= step_next;
      final_mode <= final_mode_next;
    end
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    final_mode_next = final_mode;
    in_stall        = 1'b1;
    cmd             = '0;
    cmd.emit_root   = (final_mode == vda_pkg::MODE_EUCLID);
    unique case (state)
      vda_pkg::ST_ACCUM: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          final_mode_next = status.mode;
          state_next      = vda_pkg::ST_DRAIN;
        end
      end
      vda_pkg::ST_DRAIN: begin
        cmd.clear_work = 1'b1;
        step_next      = '0;
        if (final_mode == vda_pkg::MODE_MAE) begin
          state_next = vda_pkg::ST_DIVIDE;
        end else if (final_mode == vda_pkg::MODE_EUCLID) begin
          state_next = vda_pkg::ST_ROOT;
        end else begin
          state_next = vda_pkg::ST_RESULT;
        end
      end
      vda_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == vda_pkg::STEP_W'(vda_pkg::DIV_STEPS - 1)) begin
          state_next = vda_pkg::ST_RESULT;
        end
      end
      vda_pkg::ST_ROOT: begin
        cmd.root_step  = 1'b1;
        cmd.root_first = (step == '0);
        step_next      = step + 1'b1;
        if (step == vda_pkg::STEP_W'(vda_pkg::ROOT_STEPS - 1)) begin
          state_next = vda_pkg::ST_RESULT;
        end
      end
      vda_pkg::ST_RESULT: begin
        if (!status.out_blocked) begin
          cmd.emit   = 1'b1;
          state_next = vda_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_next = vda_pkg::ST_ACCUM;
      end
    endcase
  end

endmodule

// ----- rtl/core/vda_datapath.sv -----
// Datapath for the vector distance accumulator: difference and square stage,
// saturating accumulator, shared shift-subtract divider and square root,
// and the output register. Uses vda_pkg.
module vda_datapath #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_LENGTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  vda_pkg::in_item_t  in_item,
  input  logic               distance_mode_we,
  input  logic [1:0]         distance_mode_wdata,
  input  vda_pkg::cmd_t      cmd,
  output vda_pkg::status_t   status,
  input  logic               out_stall,
  output logic               out_valid,
  output vda_pkg::out_item_t out_item
);

  localparam int USED_W = (SAMPLE_WIDTH < vda_pkg::ELEM_W) ? SAMPLE_WIDTH : vda_pkg::ELEM_W;
  localparam int MAG_W = SAMPLE_WIDTH + 1;
  localparam int TERM_W = 2 * MAG_W;
  localparam int SUM_W = ((TERM_W > vda_pkg::ACC_W) ? TERM_W : vda_pkg::ACC_W) + 1;
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);

  vda_pkg::mode_t mode;

  logic [USED_W-1:0]       a_used, b_used;
  logic                    a_sign, b_sign;
  logic [MAG_W-1:0]        a_ext, b_ext;
  logic [MAG_W:0]          diff;
  logic [MAG_W-1:0]        mag;
  logic [TERM_W-1:0]       square;
  logic                    squared;
  logic                    below_max;

  logic [TERM_W-1:0]       term;
  logic                    term_valid;
  logic [vda_pkg::ACC_W-1:0] acc, acc_next;
  logic [CNT_W-1:0]        count;
  logic                    overflow;

  logic [SUM_W-1:0]        sum;
  logic [vda_pkg::ACC_W-1:0] sum_sat;

  logic [CNT_W-1:0]        rem, rem_next;
  logic [CNT_W:0]          div_shift;
  logic                    div_ge;

  logic [vda_pkg::ROOT_W-1:0]     root_q, root_q_next;
  logic [vda_pkg::ROOT_REM_W-1:0] root_r, root_r_next;
  logic [1:0]                     root_top;
  logic [vda_pkg::ROOT_REM_W+1:0] root_shift, root_trial;
  logic                           root_ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= vda_pkg::MODE_SAD;
    end else if (distance_mode_we) begin
      mode <= vda_pkg::mode_t'(distance_mode_wdata);
    end
  end

  assign squared   = (mode == vda_pkg::MODE_SSD) || (mode == vda_pkg::MODE_EUCLID);
  assign below_max = (count < CNT_W'(MAX_LENGTH));

  always_comb begin
    a_used = in_item.elem_a[USED_W-1:0];
    b_used = in_item.elem_b[USED_W-1:0];
    a_sign = (SAMPLE_WIDTH <= vda_pkg::ELEM_W) ? a_used[USED_W-1] : 1'b0;
    b_sign = (SAMPLE_WIDTH <= vda_pkg::ELEM_W) ? b_used[USED_W-1] : 1'b0;
    a_ext  = {{(MAG_W - USED_W){a_sign}}, a_used};
    b_ext  = {{(MAG_W - USED_W){b_sign}}, b_used};
    diff   = {a_ext[MAG_W-1], a_ext} - {b_ext[MAG_W-1], b_ext};
    mag    = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
    square = TERM_W'(mag) * TERM_W'(mag);
  end

  always_ff @(posedge clk) begin
    term <= squared ? square : TERM_W'(mag);
    if (rst) begin
      term_valid <= 1'b0;
    end else begin
      term_valid <= cmd.accept && below_max;
    end
  end

  always_comb begin
    sum     = SUM_W'(acc) + SUM_W'(term);
    sum_sat = (sum > SUM_W'({vda_pkg::ACC_W{1'b1}})) ? {vda_pkg::ACC_W{1'b1}}
                                                    : sum[vda_pkg::ACC_W-1:0];

    div_shift = {rem, acc[vda_pkg::ACC_W-1]};
    div_ge    = (div_shift >= {1'b0, count});

    root_top   = cmd.root_first ? {1'b0, acc[vda_pkg::ACC_W-1]}
                                : acc[vda_pkg::ACC_W-1:vda_pkg::ACC_W-2];
    root_shift = {root_r, root_top};
    root_trial = {2'b00, root_q, 2'b01};
    root_ge    = (root_shift >= root_trial);

    acc_next    = acc;
    rem_next    = rem;
    root_q_next = root_q;
    root_r_next = root_r;
    if (cmd.clear_work) begin
      rem_next    = '0;
      root_q_next = '0;
      root_r_next = '0;
    end
    if (cmd.emit) begin
      acc_next = '0;
    end else if (cmd.div_step) begin
      acc_next = {acc[vda_pkg::ACC_W-2:0], div_ge};
      rem_next = div_ge ? CNT_W'(div_shift - {1'b0, count}) : div_shift[CNT_W-1:0];
    end else if (cmd.root_step) begin
      acc_next    = cmd.root_first ? {acc[vda_pkg::ACC_W-2:0], 1'b0}
                                   : {acc[vda_pkg::ACC_W-3:0], 2'b00};
      root_q_next = {root_q[vda_pkg::ROOT_W-2:0], root_ge};
      root_r_next = root_ge ? vda_pkg::ROOT_REM_W'(root_shift - root_trial)
                            : root_shift[vda_pkg::ROOT_REM_W-1:0];
    end else if (term_valid) begin
      acc_next = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    rem    <= rem_next;
    root_q <= root_q_next;
    root_r <= root_r_next;
    if (rst) begin
      acc      <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      acc <= acc_next;
      if (cmd.emit) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (cmd.accept) begin
        if (below_max) begin
          count <= count + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_item.distance        <= cmd.emit_root ? vda_pkg::ACC_W'(root_q) : acc;
      out_item.element_count   <= vda_pkg::COUNT_W'(count);
      out_item.length_overflow <= overflow;
    end
  end

  assign status.mode        = mode;
  assign status.out_blocked = out_valid && out_stall;

endmodule

// ----- rtl/core/vector_distance_accumulator.sv -----
// Top level of the vector distance accumulator (SAD, SSD, MAE, Euclidean).
// Instantiates vda_controller and vda_datapath; uses vda_pkg.
//
//   Channel   Handshake                    Payload
//   input     in_valid / in_stall          in_item  (elem_a, elem_b, last)
//   output    out_valid / out_stall        out_item (distance, element_count,
//                                                    length_overflow)
//   config    distance_mode_we             distance_mode_wdata
//
// Element pairs are taken back to back while accumulating. After a pair marked
// last the input stalls through the drain and result states in SAD and SSD,
// with the divide states between them in MAE (one quotient bit per cycle in
// the shift-subtract divider) and the root states in Euclidean (one root bit
// per cycle), and while the result waits behind an earlier result held in the
// output register. Loading that register frees the input. Reset is synchronous.
module vector_distance_accumulator #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_LENGTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  vda_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output vda_pkg::out_item_t out_item,
  input  logic               distance_mode_we,
  input  logic [1:0]         distance_mode_wdata
);

  vda_pkg::cmd_t    cmd;
  vda_pkg::status_t status;

  vda_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_item.last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vda_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_LENGTH   (MAX_LENGTH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .in_item             (in_item),
    .distance_mode_we    (distance_mode_we),
    .distance_mode_wdata (distance_mode_wdata),
    .cmd                 (cmd),
    .status              (status),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_item            (out_item)
  );

endmodule

// ----- rtl/core/vda_checker.sv -----
// Port-level checks for the vector distance accumulator, bound to the top.
// Uses vda_pkg and vector_distance_accumulator_assert.svh.
`include "vector_distance_accumulator_assert.svh"

module vda_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input vda_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input vda_pkg::out_item_t out_item
);

  `VDA_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid, "output valid after reset")
  `VDA_ASSERT(a_output_holds, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")
  `VDA_ASSERT(a_stall_after_last, in_valid && !in_stall && in_item.last |=> in_stall, "input taken right after a last item")

endmodule

bind vector_distance_accumulator vda_checker u_vda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ----- bench/tb_vector_distance_accumulator.sv -----
// Self-checking bench for vector_distance_accumulator: directed and random vectors in all
// four distance modes, each result compared with a scoreboard that predicts it.
// Depends on vda_pkg and the RTL of the block only.
module tb_vector_distance_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_PAIRS = 4096;
  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned SUM_MAX = (64'd1 << vda_pkg::ACC_W) - 1;
  localparam logic signed [vda_pkg::ELEM_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [vda_pkg::ELEM_W-1:0] S_MAX = 16'sh7fff;

  class distance_scoreboard;
    vda_pkg::mode_t mode = vda_pkg::MODE_SAD;
    longint unsigned sum_acc;
    int unsigned pair_count;
    bit overflow_seen;
    vda_pkg::out_item_t expected_q[$];
    int mismatches;
    int checked;

    function void note_input(vda_pkg::in_item_t it);
      longint signed diff;
      longint unsigned mag, term, want_dist, trial;
      vda_pkg::out_item_t res;
      diff = longint'($signed(it.elem_a)) - longint'($signed(it.elem_b));
      mag = (diff < 0) ? -diff : diff;
      term = (mode == vda_pkg::MODE_SSD || mode == vda_pkg::MODE_EUCLID) ? mag * mag : mag;
      if (pair_count >= MAX_PAIRS) begin
        overflow_seen = 1'b1;
      end else begin
        sum_acc = (sum_acc + term > SUM_MAX) ? SUM_MAX : sum_acc + term;
        pair_count++;
      end
      if (!it.last) return;
      case (mode)
        vda_pkg::MODE_MAE: begin
          want_dist = (pair_count == 0) ? 0 : sum_acc / pair_count;
        end
        vda_pkg::MODE_EUCLID: begin
          want_dist = 0;
          for (int i = vda_pkg::ROOT_W - 1; i >= 0; i--) begin
            trial = want_dist | (64'd1 << i);
            if (trial * trial <= sum_acc) want_dist = trial;
          end
        end
        default: begin
          want_dist = sum_acc;
        end
      endcase
      res.distance = want_dist[vda_pkg::ACC_W-1:0];
      res.element_count = pair_count[vda_pkg::COUNT_W-1:0];
      res.length_overflow = overflow_seen;
      expected_q.push_back(res);
      sum_acc = 0;
      pair_count = 0;
      overflow_seen = 1'b0;
    endfunction

    function void check_result(vda_pkg::out_item_t got);
      vda_pkg::out_item_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d not expected: distance %0d count %0d overflow %0b",
                   checked, got.distance, got.element_count, got.length_overflow);
        return;
      end
      want = expected_q.pop_front();
      if (got.distance !== want.distance || got.element_count !== want.element_count ||
          got.length_overflow !== want.length_overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected distance %0d count %0d overflow %0b, got %0d %0d %0b",
                   checked, want.distance, want.element_count, want.length_overflow,
                   got.distance, got.element_count, got.length_overflow);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  vda_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vda_pkg::out_item_t out_item;
  logic distance_mode_we = 1'b0;
  logic [1:0] distance_mode_wdata = '0;
  distance_scoreboard sb = new;

  vector_distance_accumulator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .distance_mode_we(distance_mode_we),
    .distance_mode_wdata(distance_mode_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [vda_pkg::ELEM_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return S_MIN;
    if (r == 1) return S_MAX;
    if (r < 4) return vda_pkg::ELEM_W'($urandom_range(0, 16) - 8);
    return vda_pkg::ELEM_W'($urandom());
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic send_pair(logic signed [vda_pkg::ELEM_W-1:0] a,
                           logic signed [vda_pkg::ELEM_W-1:0] b, logic last);
    vda_pkg::in_item_t it;
    it.elem_a = a;
    it.elem_b = b;
    it.last = last;
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic hold_input(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_vector(int len, bit calm);
    for (int i = 0; i < len; i++) begin
      send_pair(pick_sample(), pick_sample(), i == len - 1);
      if (!calm) hold_input(pick_gap());
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(vda_pkg::mode_t m);
    distance_mode_we <= 1'b1;
    distance_mode_wdata <= m;
    @(posedge clk);
    sb.mode = m;
    distance_mode_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end

  initial begin : result_pacer
    int stall_left;
    int calm_left;
    bit held;
    stall_left = 0;
    calm_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.checked >= 40) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 300);
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    bit calm;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_mode(vda_pkg::MODE_SAD);
    send_pair(S_MAX, S_MIN, 1'b1);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b1);
    settle();
    write_mode(vda_pkg::MODE_SSD);
    send_pair(S_MAX, S_MIN, 1'b1);
    send_pair(-16'sd1, 16'sd1, 1'b0);
    hold_input(3);
    send_pair(16'sd5, 16'sd5, 1'b0);
    send_pair(16'sd100, -16'sd100, 1'b1);
    settle();
    write_mode(vda_pkg::MODE_MAE);
    send_pair(16'sd10, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd3, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(S_MIN, S_MAX, 1'b1);
    settle();
    write_mode(vda_pkg::MODE_EUCLID);
    send_pair(16'sd3, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd4, 1'b1);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MAX, S_MIN, 1'b1);

    // The mode changes between pairs of one vector.
    settle();
    write_mode(vda_pkg::MODE_SAD);
    send_pair(16'sd7, 16'sd0, 1'b0);
    send_pair(16'sd0, -16'sd2, 1'b0);
    settle();
    write_mode(vda_pkg::MODE_SSD);
    send_pair(16'sd3, 16'sd0, 1'b1);
    send_pair(16'sd10, 16'sd0, 1'b0);
    settle();
    write_mode(vda_pkg::MODE_MAE);
    send_pair(16'sd0, 16'sd4, 1'b1);

    for (int p = 0; p < 10; p++) begin
      settle();
      write_mode(p < 4 ? vda_pkg::mode_t'(p) : vda_pkg::mode_t'($urandom_range(0, 3)));
      calm = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 85) begin
        len = pick_length();
        send_vector(len, calm);
        sent += len;
      end
    end
    settle();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("vector_distance_accumulator: match");
    end else begin
      $display("vector_distance_accumulator: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("vector_distance_accumulator: mismatch");
    $finish;
  end
endmodule
